### rtl/core/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_PER_COUNT = 8'd1;
  localparam logic [15:0] RESOLUTION_RST = 16'd1000;
  localparam logic [31:0] RAD_PER_COUNT_RST = 32'd1030792;
  localparam logic signed [36:0] TWO_PI_Q32 = 37'sd26986075409;
  localparam logic signed [36:0] PI_Q32 = 37'sd13493037705;
  localparam logic signed [36:0] HALF_PI_Q32 = 37'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam int unsigned ANG_W = 65;

  // arctangent of 2^-i, 32 fraction bits
  function automatic logic signed [36:0] atan_step(input logic [5:0] i);
    logic signed [36:0] v;
    v = '0;
    case (i)
      6'd0: v = 37'sd3373259426;
      6'd1: v = 37'sd1991351318;
      6'd2: v = 37'sd1052175346;
      6'd3: v = 37'sd534100635;
      6'd4: v = 37'sd268086748;
      6'd5: v = 37'sd134174063;
      6'd6: v = 37'sd67103403;
      6'd7: v = 37'sd33553749;
      6'd8: v = 37'sd16777131;
      6'd9: v = 37'sd8388597;
      6'd10: v = 37'sd4194303;
      default: begin
        if (i < 6'd32) v = 37'sd1 <<< (6'd32 - i);
      end
    endcase
    return v;
  endfunction
endpackage

### rtl/core/ddo_if.sv
`timescale 1ns / 1ps
interface ddo_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] count_right;
  logic signed [31:0] count_left;
  modport source(output valid, count_right, count_left, input ready);
  modport sink(input valid, count_right, count_left, output ready);
endinterface

interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [25:0] speed_right;
  logic signed [25:0] speed_left;
  logic signed [31:0] x_mm;
  logic signed [31:0] y_mm;
  modport source(output valid, speed_right, speed_left, x_mm, y_mm, input ready);
  modport sink(input valid, speed_right, speed_left, x_mm, y_mm, output ready);
endinterface

interface ddo_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/ddo_divider.sv
`timescale 1ns / 1ps
// Bit-serial signed divider: restoring, one quotient bit a cycle,
// truncated toward zero. Quotient wraps to 32 bits.
module ddo_divider
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] dividend,
  input  logic [16:0]        divisor,
  output logic               done,
  output logic [31:0]        quotient
);
  logic [39:0] mag_r, mag_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dvs_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [17:0] trial;

  assign trial = {rem_r, mag_r[39]} - {1'b0, dvs_r};

  always_comb begin
    rem_nxt = {rem_r[15:0], mag_r[39]};
    mag_nxt = {mag_r[38:0], 1'b0};
    if (!trial[17]) begin
      rem_nxt = trial[16:0];
      mag_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mag_r  <= dividend[39] ? 40'(-dividend) : dividend;
        neg_r  <= dividend[39];
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        mag_r <= mag_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd39) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg_r ? 32'(-mag_r) : mag_r[31:0];
endmodule

### rtl/core/ddo_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC, one rotation per cycle. Angle in Q32, outputs Q30.
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [36:0] angle,
  input  logic               flip,
  output logic               done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);
  localparam int CNT_W = $clog2(STEPS + 1);
  logic signed [33:0] x_r, y_r;
  logic signed [37:0] z_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, flip_r;
  logic signed [33:0] dx, dy;
  logic [5:0]         idx;

  assign idx = 6'(cnt_r);
  assign dx = y_r >>> idx;
  assign dy = x_r >>> idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x_r    <= CORDIC_GAIN_Q30;
        y_r    <= '0;
        z_r    <= 38'(angle);
        flip_r <= flip;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!z_r[37]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - 38'(atan_step(idx));
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + 38'(atan_step(idx));
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign cos_q30 = flip_r ? -x_r : x_r;
  assign sin_q30 = flip_r ? -y_r : y_r;
endmodule

### rtl/core/differential_drive_odometry_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_     | in  | count_right, count_left (32b signed each)
// out_    | out | speed_right, speed_left (26b), x_mm, y_mm (32b)
// cfg_    | in  | index 8b, data 32b
// One request at a time; from accept to result it runs a serial heading
// multiply, a serial modulo 2pi and fold, the CORDIC, a multiply-accumulate
// for both axes in S_MAC, then two passes of a divider pair: speeds, then
// millimetres. Synchronous active-low reset.
// A held result does not block the next request; a newer result waits in
// S_OUT until the held one is taken, and the input stalls meanwhile.
module differential_drive_odometry_unit
  import ddo_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst_n,
  ddo_in_if.sink    in_ch,
  ddo_out_if.source out_ch,
  ddo_cfg_if.sink   cfg_ch
);
  localparam int SH = 30 - TRIG_FRAC_BITS;
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MOD, S_CORD, S_CWAIT, S_MAC, S_SPD, S_SWAIT, S_MM, S_MWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] res_r;
  logic [31:0] rpc_r;
  logic [31:0] last_r_r, last_l_r, last_m_r, pos_x_r, pos_y_r;
  logic signed [31:0] dr_r, dl_r, step_r;
  logic [63:0] prod_r;
  logic [31:0] mcand_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic signed [65:0] ang_r;
  logic signed [36:0] zred;
  logic signed [33:0] cos_r, sin_r;
  logic signed [63:0] accx_r, accy_r;
  logic        cstart_r, dstart_r;
  logic signed [39:0] dv0, dv1;
  logic [16:0] dvs;
  logic        d0_done, d1_done, c_done;
  logic [31:0] q0, q1;
  logic signed [33:0] c_cos, c_sin;
  logic        sel_r;
  logic        out_valid_r;
  logic        out_load;
  logic [25:0] spd_right_r, spd_left_r;
  logic [25:0] o_sr_r, o_sl_r;
  logic [31:0] o_x_r, o_y_r;
  logic signed [33:0] tc, ts;
  logic signed [36:0] z_cord;
  logic        z_flip;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.speed_right = o_sr_r;
  assign out_ch.speed_left = o_sl_r;
  assign out_ch.x_mm = o_x_r;
  assign out_ch.y_mm = o_y_r;

  // result moves into the output register once it is free
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // centered heading and quadrant fold
  always_comb begin
    zred = 37'(ang_r);
    if (zred >= PI_Q32) zred = zred - TWO_PI_Q32;
    z_cord = zred;
    z_flip = 1'b0;
    if (zred > HALF_PI_Q32) begin
      z_cord = zred - PI_Q32;
      z_flip = 1'b1;
    end else if (zred < -HALF_PI_Q32) begin
      z_cord = zred + PI_Q32;
      z_flip = 1'b1;
    end
  end

  assign tc = (c_cos + (34'sd1 <<< SH) / 2) >>> SH;
  assign ts = (c_sin + (34'sd1 <<< SH) / 2) >>> SH;
  assign dvs = (res_r == 16'd0) ? 17'd1 : {1'b0, res_r};

  always_comb begin
    if (!sel_r) begin
      dv0 = 40'(dr_r);
      dv1 = 40'(dl_r);
    end else begin
      dv0 = 40'(accx_r >>> TRIG_FRAC_BITS) * 40'sd100;
      dv1 = 40'(accy_r >>> TRIG_FRAC_BITS) * 40'sd100;
    end
  end

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cstart_r), .angle(z_cord), .flip(z_flip),
    .done(c_done), .cos_q30(c_cos), .sin_q30(c_sin)
  );
  ddo_divider u_div0 (
    .clk, .rst_n, .start(dstart_r), .dividend(dv0),
    .divisor(sel_r ? dvs : 17'd100), .done(d0_done), .quotient(q0)
  );
  ddo_divider u_div1 (
    .clk, .rst_n, .start(dstart_r), .dividend(dv1),
    .divisor(sel_r ? dvs : 17'd100), .done(d1_done), .quotient(q1)
  );

  logic signed [63:0] tx, ty;
  always_comb begin
    tx = (64'(signed'(pos_x_r)) <<< TRIG_FRAC_BITS) + 64'(step_r) * 64'(cos_r);
    ty = (64'(signed'(pos_y_r)) <<< TRIG_FRAC_BITS) + 64'(step_r) * 64'(sin_r);
  end
  logic signed [63:0] tnx, tny;
  assign tnx = tx[63] ? tx + ((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1) : tx;
  assign tny = ty[63] ? ty + ((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1) : ty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= RESOLUTION_RST;
      rpc_r       <= RAD_PER_COUNT_RST;
      last_r_r    <= '0;
      last_l_r    <= '0;
      last_m_r    <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
      cstart_r    <= 1'b0;
      dstart_r    <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      cstart_r <= 1'b0;
      dstart_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_RESOLUTION) res_r <= cfg_ch.data[15:0];
        else if (cfg_ch.index == REG_RAD_PER_COUNT) rpc_r <= cfg_ch.data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            dr_r   <= in_ch.count_right - last_r_r;
            dl_r   <= in_ch.count_left - last_l_r;
            last_r_r <= in_ch.count_right;
            last_l_r <= in_ch.count_left;
            begin
              logic signed [32:0] s;
              logic [31:0] m, d;
              s = 33'(in_ch.count_right) + 33'(in_ch.count_left);
              m = 32'((s + (s[32] ? 33'sd1 : 33'sd0)) >>> 1);
              step_r   <= m - last_m_r;
              last_m_r <= m;
              d = in_ch.count_right - in_ch.count_left;
              neg_r   <= d[31];
              mcand_r <= d[31] ? -d : d;
            end
            prod_r <= '0;
            cnt_r  <= '0;
            state_r <= S_MUL;
          end
        end
        // shift-add multiply, one multiplier bit a cycle
        S_MUL: begin
          prod_r <= (prod_r >> 1) + (rpc_r[cnt_r[4:0]] ? {mcand_r, 32'd0} >> 1 : 64'd0);
          if (cnt_r == 6'd31) begin
            state_r <= S_MOD;
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        // finish sign, then reduce modulo 2pi one quotient bit a cycle
        S_MOD: begin
          if (cnt_r == 6'd0) begin
            logic signed [65:0] a;
            a = neg_r ? -66'(prod_r) : 66'(prod_r);
            ang_r <= a;
            cnt_r <= 6'd1;
          end else begin
            logic signed [65:0] t;
            logic [5:0] k;
            k = 6'd30 - (cnt_r - 6'd1);
            t = ang_r[65] ? ang_r + (66'(TWO_PI_Q32) <<< k)
                          : ang_r - (66'(TWO_PI_Q32) <<< k);
            if (ang_r[65] || t >= 0) ang_r <= t;
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd31) state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (ang_r[65]) ang_r <= ang_r + 66'(TWO_PI_Q32);
          else if (ang_r >= 66'(TWO_PI_Q32)) ang_r <= ang_r - 66'(TWO_PI_Q32);
          else begin
            cstart_r <= 1'b1;
            state_r <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (c_done) begin
            cos_r <= tc;
            sin_r <= ts;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          accx_r <= tnx;
          accy_r <= tny;
          pos_x_r <= 32'(tnx >>> TRIG_FRAC_BITS);
          pos_y_r <= 32'(tny >>> TRIG_FRAC_BITS);
          sel_r <= 1'b0;
          state_r <= S_SPD;
        end
        S_SPD: begin
          dstart_r <= 1'b1;
          state_r <= S_SWAIT;
        end
        S_SWAIT: begin
          if (d0_done) begin
            spd_right_r <= q0[25:0];
            spd_left_r  <= q1[25:0];
            sel_r <= 1'b1;
            accx_r <= 64'(signed'(pos_x_r)) <<< TRIG_FRAC_BITS;
            accy_r <= 64'(signed'(pos_y_r)) <<< TRIG_FRAC_BITS;
            state_r <= S_MM;
          end
        end
        S_MM: begin
          dstart_r <= 1'b1;
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (d0_done && d1_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            o_sr_r <= spd_right_r;
            o_sl_r <= spd_left_r;
            o_x_r <= q0;
            o_y_r <= q1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result dropped");
  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    d0_done == d1_done) else $error("dividers out of step");
`endif
endmodule

### tb/ddo_tb_if.sv
`timescale 1ns / 1ps
// Interfaces come from the RTL file ddo_if.sv; this file holds only the watchdog limit package.
package ddo_tb_pkg;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
endpackage

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ddo_pkg::*;
  import ddo_tb_pkg::*;

  typedef struct packed {
    logic signed [25:0] speed_right;
    logic signed [25:0] speed_left;
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
  } odo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ddo_in_if  in_ch();
  ddo_out_if out_ch();
  ddo_cfg_if cfg_ch();

  differential_drive_odometry_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [15:0] resolution;
  logic [31:0] rad_per_count;
  logic [31:0] prev_right, prev_left, prev_mean, acc_x, acc_y;
  odo_result_t expected_pose_q[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  function automatic longint floor_div2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint trunc_div2(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic longint atan_q32(int i);
    longint t [11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
                       64'sd534100635, 64'sd268086748, 64'sd134174063,
                       64'sd67103403, 64'sd33553749, 64'sd16777131,
                       64'sd8388597, 64'sd4194303};
    if (i < 11) return t[i];
    if (i < 32) return longint'(1) << (32 - i);
    return 0;
  endfunction

  function automatic void heading_trig(longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy, half;
    bit flip;
    x = CORDIC_GAIN_Q30;
    y = 0;
    flip = 1'b0;
    z = ang % TWO_PI_Q32;
    if (z < 0) z += TWO_PI_Q32;
    if (z >= PI_Q32) z -= TWO_PI_Q32;
    if (z > HALF_PI_Q32) begin
      z -= PI_Q32;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q32) begin
      z += PI_Q32;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_div2(y, i);
      dy = floor_div2(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q32(i);
      end else begin
        x += dx; y -= dy; z += atan_q32(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    half = longint'(1) << 13;
    c = floor_div2(x + half, 14);
    s = floor_div2(y + half, 14);
  endfunction

  function automatic logic [31:0] accumulate_axis(logic [31:0] pos, longint step,
                                                  longint trig);
    longint sum;
    sum = longint'($signed(pos)) * 65536 + step * trig;
    return 32'(trunc_div2(sum, 16));
  endfunction

  function automatic logic [31:0] to_mm(logic [31:0] pos);
    longint d;
    d = (resolution == 0) ? 1 : longint'(resolution);
    return 32'((longint'($signed(pos)) * 100) / d);
  endfunction

  function automatic odo_result_t predict_pose(logic [31:0] r, logic [31:0] l);
    odo_result_t res;
    longint dr, dl, sum, step, diff, c, s;
    logic [31:0] mean;
    dr = longint'($signed(r - prev_right));
    dl = longint'($signed(l - prev_left));
    sum = longint'($signed(r)) + longint'($signed(l));
    mean = 32'(sum / 2);
    step = longint'($signed(mean - prev_mean));
    diff = longint'($signed(r - l));
    prev_right = r;
    prev_left = l;
    prev_mean = mean;
    heading_trig(diff * longint'(rad_per_count), c, s);
    acc_x = accumulate_axis(acc_x, step, c);
    acc_y = accumulate_axis(acc_y, step, s);
    res.speed_right = 26'(dr / 100);
    res.speed_left = 26'(dl / 100);
    res.x_mm = to_mm(acc_x);
    res.y_mm = to_mm(acc_y);
    return res;
  endfunction

  // send one tick request
  task automatic send_tick(logic [31:0] r, logic [31:0] l);
    while (($urandom % 100) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.count_right <= r;
    in_ch.count_left <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_pose_q.push_back(predict_pose(r, l));
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_pose_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_RESOLUTION) resolution = val[15:0];
    else if (idx == REG_RAD_PER_COUNT) rad_per_count = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 4000)) - 2000);
      2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(0, 3);
      default: return prev_right + 32'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // extremes and every register path
  task automatic test_directed();
    logic [31:0] v [6] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                           32'd1, 32'd100};
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 3; j++) send_tick(v[i], v[(i + j + 1) % 6]);
    drain();
    write_reg(REG_RESOLUTION, 32'd0);
    write_reg(REG_RAD_PER_COUNT, 32'hffff_ffff);
    send_tick(32'h7fff_ffff, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7fff_ffff);
    send_tick(32'd12345, 32'd12000);
    drain();
    write_reg(REG_RESOLUTION, 32'd65535);
    write_reg(REG_RAD_PER_COUNT, 32'd0);
    send_tick(32'd5000, 32'd1000);
    send_tick(32'hffff_0000, 32'h0000_ffff);
    drain();
  endtask

  // random ticks under several register settings
  task automatic test_random(int n);
    logic [31:0] r;
    for (int i = 0; i < n; i++) begin
      if (i % 130 == 0) begin
        drain();
        write_reg(REG_RESOLUTION, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                  : $urandom_range(1, 2000));
        write_reg(REG_RAD_PER_COUNT, $urandom_range(0, 2) == 0 ? $urandom
                                     : $urandom_range(0, 4000000));
      end
      r = rand_count();
      send_tick(r, ($urandom_range(0, 3) == 0) ? $urandom
                   : r + 32'($signed($urandom_range(0, 2000)) - 1000));
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_tick($urandom, $urandom);
    join
    drain();
  endtask

  // receiver and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", {out_ch.speed_right,
            out_ch.speed_left, out_ch.x_mm, out_ch.y_mm});
        end else begin
          odo_result_t e;
          e = expected_pose_q.pop_front();
          if (e.speed_right !== out_ch.speed_right || e.speed_left !== out_ch.speed_left ||
              e.x_mm !== out_ch.x_mm || e.y_mm !== out_ch.y_mm) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp sr=%0d sl=%0d x=%0d y=%0d got sr=%0d sl=%0d x=%0d y=%0d",
                e.speed_right, e.speed_left, e.x_mm, e.y_mm, out_ch.speed_right,
                out_ch.speed_left, out_ch.x_mm, out_ch.y_mm);
          end
        end
      end
      out_ch.ready <= !recv_hold && (($urandom % 100) >= recv_idle_pct);
    end
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || recv_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.count_right = '0;
    in_ch.count_left = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    resolution = RESOLUTION_RST;
    rad_per_count = RAD_PER_COUNT_RST;
    prev_right = '0; prev_left = '0; prev_mean = '0; acc_x = '0; acc_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 32; recv_idle_pct = 60;
    test_directed();
    test_random(500);
    send_idle_pct = 60; recv_idle_pct = 32;
    test_random(500);
    test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(520);
    drain();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

### differential_drive_odometry_unit.f
rtl/core/ddo_pkg.sv
rtl/core/ddo_if.sv
rtl/core/ddo_divider.sv
rtl/core/ddo_cordic.sv
rtl/core/differential_drive_odometry_unit.sv
tb/ddo_tb_if.sv
tb/testbench.sv
